@@ src/gbn_pkg.sv @@
// Shared types, constants and command codes of the Go-Back-N sender window.
`timescale 1ns / 1ps

package gbn_pkg;

	localparam int SEQ_W       = 3;
	localparam int TAG_W       = 32;
	localparam int CMD_W       = 2;
	localparam int SLIDE_W     = 3;
	localparam int DEF_WINDOW  = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

	typedef enum logic [1:0] {
		OP_SEND,
		OP_ACK,
		OP_TIMEOUT,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [TAG_W-1:0]  payload_tag;
		logic [SEQ_W-1:0]  ack_number;
		logic [SEQ_W-1:0]  expired_seq;
	} item_t;

	typedef struct packed {
		logic               send_accepted;
		logic               packet_valid;
		logic [SEQ_W-1:0]   packet_seq;
		logic [TAG_W-1:0]   packet_payload;
		logic               timer_stop;
		logic [SEQ_W-1:0]   timer_stop_seq;
		logic               timer_start;
		logic [SEQ_W-1:0]   timer_start_seq;
		logic [SLIDE_W-1:0] slide_amount;
		logic [SEQ_W-1:0]   window_base;
		logic               last;
	} res_t;

endpackage

@@ src/gbn_front.sv @@
// Request intake: handshake and command classification ahead of the queue.
`timescale 1ns / 1ps

module gbn_front
	import gbn_pkg::*;
(
	input  logic              start,
	output logic              busy,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [TAG_W-1:0]  payload_tag,
	input  logic [SEQ_W-1:0]  ack_number,
	input  logic              ack_check_ok,
	input  logic [SEQ_W-1:0]  expired_seq,
	input  logic              q_full,
	output logic              q_push,
	output item_t             q_item
);

	op_t op;

	// An ack whose checksum failed can never move the window, so it is
	// folded into the no-op class here.
	always_comb begin
		unique case (cmd)
			CMD_SEND:    op = OP_SEND;
			CMD_ACK:     op = ack_check_ok ? OP_ACK : OP_NOP;
			CMD_TIMEOUT: op = OP_TIMEOUT;
			default:     op = OP_NOP;
		endcase
	end

	assign busy   = q_full;
	assign q_push = start && !q_full;

	assign q_item.op          = op;
	assign q_item.payload_tag = payload_tag;
	assign q_item.ack_number  = ack_number;
	assign q_item.expired_seq = expired_seq;

endmodule

@@ src/gbn_queue.sv @@
// Short request queue between the intake and the window engine.
`timescale 1ns / 1ps

module gbn_queue
	import gbn_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head_item,
	output logic  empty,
	output logic  full
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
		else r = p + PTR_W'(1);
		return r;
	endfunction

	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_item = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

@@ src/gbn_back.sv @@
// Window engine: held-packet ring, ack search, retransmission and result register.
`timescale 1ns / 1ps

module gbn_back
	import gbn_pkg::*;
#(
	parameter int WINDOW = DEF_WINDOW
) (
	input  logic  clk,
	input  logic  arst_n,
	input  item_t head_item,
	input  logic  empty,
	output logic  pop,
	output logic  strobe,
	output res_t  res
);

	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int SUM_W = CNT_W + 1;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_RESEND = 2'd2;

	logic [1:0]       state_q, state_d;
	logic [SEQ_W-1:0] base_q, base_d;
	logic [SEQ_W-1:0] next_q, next_d;
	logic [CNT_W-1:0] outstanding_q, outstanding_d;
	logic [IDX_W-1:0] head_q, head_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [SEQ_W-1:0] ackn_q, ackn_d;
	logic [SEQ_W-1:0] exp_q, exp_d;

	logic [SEQ_W-1:0] mem_seq [WINDOW];
	logic [TAG_W-1:0] mem_pay [WINDOW];
	logic [SEQ_W-1:0] rd_seq_q;
	logic [TAG_W-1:0] rd_pay_q;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;

	logic             strobe_q, emit;
	res_t             res_q, res_d;

	logic [CNT_W-1:0] idx_cnt;
	logic             idx_is_last;
	logic [CNT_W-1:0] freed;
	logic [CNT_W-1:0] remain;

	function automatic logic [IDX_W-1:0] ring(input logic [SUM_W-1:0] s);
		logic [IDX_W-1:0] r;
		if (s >= SUM_W'(WINDOW)) r = IDX_W'(s - SUM_W'(WINDOW));
		else r = IDX_W'(s);
		return r;
	endfunction

	assign idx_cnt     = CNT_W'(idx_q);
	assign idx_is_last = (idx_cnt + CNT_W'(1) == outstanding_q);
	assign freed       = idx_cnt + CNT_W'(1);
	assign remain      = outstanding_q - freed;
	assign pop         = (state_q == ST_IDLE) && !empty;

	// The read port always looks one entry ahead of the walk so that the
	// registered data lines up with idx_q in the following cycle.
	always_comb begin
		if (state_q == ST_IDLE) rd_addr = head_q;
		else rd_addr = ring(SUM_W'(head_q) + SUM_W'(idx_q) + SUM_W'(1));
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_seq[wr_addr] <= next_q;
			mem_pay[wr_addr] <= head_item.payload_tag;
		end
		rd_seq_q <= mem_seq[rd_addr];
		rd_pay_q <= mem_pay[rd_addr];
	end

	always_comb begin
		state_d       = state_q;
		base_d        = base_q;
		next_d        = next_q;
		outstanding_d = outstanding_q;
		head_d        = head_q;
		idx_d         = idx_q;
		ackn_d        = ackn_q;
		exp_d         = exp_q;
		wr_en         = 1'b0;
		wr_addr       = ring(SUM_W'(head_q) + SUM_W'(outstanding_q));
		emit          = 1'b0;
		res_d         = '0;
		res_d.window_base = base_q;
		res_d.last    = 1'b1;

		unique case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					ackn_d = head_item.ack_number;
					exp_d  = head_item.expired_seq;
					idx_d  = '0;
					unique case (head_item.op)
						OP_SEND: begin
							emit = 1'b1;
							if (outstanding_q < CNT_W'(WINDOW)) begin
								wr_en                = 1'b1;
								next_d               = next_q + SEQ_W'(1);
								outstanding_d        = outstanding_q + CNT_W'(1);
								res_d.send_accepted  = 1'b1;
								res_d.packet_valid   = 1'b1;
								res_d.packet_seq     = next_q;
								res_d.packet_payload = head_item.payload_tag;
								if (outstanding_q == '0) begin
									res_d.timer_start     = 1'b1;
									res_d.timer_start_seq = next_q;
								end
							end
						end
						OP_ACK: begin
							if (outstanding_q == '0) emit = 1'b1;
							else state_d = ST_SEARCH;
						end
						OP_TIMEOUT: begin
							if (outstanding_q == '0) begin
								emit                  = 1'b1;
								res_d.timer_stop      = 1'b1;
								res_d.timer_stop_seq  = head_item.expired_seq;
								res_d.timer_start     = 1'b1;
								res_d.timer_start_seq = head_item.expired_seq;
							end else begin
								state_d = ST_RESEND;
							end
						end
						default: emit = 1'b1;
					endcase
				end
			end
			ST_SEARCH: begin
				if (rd_seq_q == ackn_q) begin
					// Cumulative ack: everything up to and including the match goes.
					emit                 = 1'b1;
					state_d              = ST_IDLE;
					head_d               = ring(SUM_W'(head_q) + SUM_W'(freed));
					outstanding_d        = remain;
					base_d               = ackn_q + SEQ_W'(1);
					res_d.window_base    = ackn_q + SEQ_W'(1);
					res_d.timer_stop     = 1'b1;
					res_d.timer_stop_seq = base_q;
					res_d.slide_amount   = SLIDE_W'(freed);
					if (remain != '0) begin
						res_d.timer_start     = 1'b1;
						res_d.timer_start_seq = ackn_q + SEQ_W'(1);
					end
				end else if (idx_is_last) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			ST_RESEND: begin
				emit                 = 1'b1;
				res_d.packet_valid   = 1'b1;
				res_d.packet_seq     = rd_seq_q;
				res_d.packet_payload = rd_pay_q;
				res_d.last           = idx_is_last;
				if (idx_q == '0) begin
					res_d.timer_stop      = 1'b1;
					res_d.timer_stop_seq  = exp_q;
					res_d.timer_start     = 1'b1;
					res_d.timer_start_seq = exp_q;
				end
				if (idx_is_last) state_d = ST_IDLE;
				else idx_d = idx_q + IDX_W'(1);
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			base_q        <= '0;
			next_q        <= '0;
			outstanding_q <= '0;
			head_q        <= '0;
			idx_q         <= '0;
			strobe_q      <= 1'b0;
		end else begin
			state_q       <= state_d;
			base_q        <= base_d;
			next_q        <= next_d;
			outstanding_q <= outstanding_d;
			head_q        <= head_d;
			idx_q         <= idx_d;
			strobe_q      <= emit;
		end
	end

	always_ff @(posedge clk) begin
		ackn_q <= ackn_d;
		exp_q  <= exp_d;
		if (emit) res_q <= res_d;
	end

	assign strobe = strobe_q;
	assign res    = res_q;

endmodule

@@ src/go_back_n_sender_window.sv @@
// Top level of the Go-Back-N sender window.
`timescale 1ns / 1ps

// Requests enter on start while busy is low and wait in a two-entry queue; the
// window engine behind it takes one request at a time. Send, unknown commands,
// failed acks and timeouts with an empty window are answered from the idle
// state. An ack walks the held-packet ring one entry per cycle until it matches
// or reaches the last outstanding entry. A timeout with N packets outstanding
// reads the oldest first and then emits one packet per cycle, N in all. Each
// result is registered and appears on the result ports in the cycle after the
// engine produces it, with strobe high for exactly one cycle; the receiver has no
// way to stall, so results must be captured when strobe is high. Results of a
// retransmission come in consecutive cycles, with last on the final one.
module go_back_n_sender_window
	import gbn_pkg::*;
#(
	parameter int WINDOW = DEF_WINDOW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [TAG_W-1:0]   payload_tag,
	input  logic [SEQ_W-1:0]   ack_number,
	input  logic               ack_check_ok,
	input  logic [SEQ_W-1:0]   expired_seq,
	output logic               strobe,
	output logic               send_accepted,
	output logic               packet_valid,
	output logic [SEQ_W-1:0]   packet_seq,
	output logic [TAG_W-1:0]   packet_payload,
	output logic               timer_stop,
	output logic [SEQ_W-1:0]   timer_stop_seq,
	output logic               timer_start,
	output logic [SEQ_W-1:0]   timer_start_seq,
	output logic [SLIDE_W-1:0] slide_amount,
	output logic [SEQ_W-1:0]   window_base,
	output logic               last
);

	logic  q_push, q_pop, q_empty, q_full;
	item_t q_in, q_head;
	res_t  res;

	gbn_front u_front (
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.payload_tag  (payload_tag),
		.ack_number   (ack_number),
		.ack_check_ok (ack_check_ok),
		.expired_seq  (expired_seq),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (q_in)
	);

	gbn_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.pop       (q_pop),
		.head_item (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	gbn_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_item (q_head),
		.empty     (q_empty),
		.pop       (q_pop),
		.strobe    (strobe),
		.res       (res)
	);

	assign send_accepted   = res.send_accepted;
	assign packet_valid    = res.packet_valid;
	assign packet_seq      = res.packet_seq;
	assign packet_payload  = res.packet_payload;
	assign timer_stop      = res.timer_stop;
	assign timer_stop_seq  = res.timer_stop_seq;
	assign timer_start     = res.timer_start;
	assign timer_start_seq = res.timer_start_seq;
	assign slide_amount    = res.slide_amount;
	assign window_base     = res.window_base;
	assign last            = res.last;

endmodule

@@ src/gbn_checker.sv @@
// Port-level checks of the sender window, bound to the top level.
`timescale 1ns / 1ps

module gbn_checker
	import gbn_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               strobe,
	input logic               send_accepted,
	input logic               packet_valid,
	input logic               timer_stop,
	input logic [SLIDE_W-1:0] slide_amount,
	input logic               last
);

	// An accepted send is always a single result carrying its packet.
	a_send_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && send_accepted |-> packet_valid && last)
		else $error("accepted send without packet or not last");

	// A sliding ack stops the old timer and carries no packet.
	a_slide_shape: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (slide_amount != '0) |-> timer_stop && !packet_valid && last)
		else $error("sliding ack result malformed");

	// Retransmitted packets follow each other in consecutive cycles.
	a_resend_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && packet_valid && !last |=> strobe && packet_valid)
		else $error("gap inside retransmission burst");

	// Only the first result of a retransmission carries the timer stop request; none is an accepted send.
	a_resend_timer: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && packet_valid && !last |=> !timer_stop && !send_accepted)
		else $error("timer request repeated inside retransmission");

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (.*);

@@ bench/go_back_n_sender_window_tb.sv @@
// Self-checking testbench for the Go-Back-N sender window: directed and random requests.
`timescale 1ns / 1ps

module go_back_n_sender_window_tb;
	import gbn_pkg::*;

	localparam int WIN        = DEF_WINDOW;
	localparam int RANDOM_REQS = 500;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int PRINT_CAP  = 50;

	typedef struct {
		op_t              op;
		logic [TAG_W-1:0] tag;
		logic [SEQ_W-1:0] ackn;
		logic             ok;
		logic [SEQ_W-1:0] expired;
		bit               pause;
	} request_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [CMD_W-1:0]   cmd = '0;
	logic [TAG_W-1:0]   payload_tag = '0;
	logic [SEQ_W-1:0]   ack_number = '0;
	logic               ack_check_ok = 1'b0;
	logic [SEQ_W-1:0]   expired_seq = '0;
	logic               strobe;
	logic               send_accepted;
	logic               packet_valid;
	logic [SEQ_W-1:0]   packet_seq;
	logic [TAG_W-1:0]   packet_payload;
	logic               timer_stop;
	logic [SEQ_W-1:0]   timer_stop_seq;
	logic               timer_start;
	logic [SEQ_W-1:0]   timer_start_seq;
	logic [SLIDE_W-1:0] slide_amount;
	logic [SEQ_W-1:0]   window_base;
	logic               last;

	go_back_n_sender_window uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.payload_tag(payload_tag), .ack_number(ack_number), .ack_check_ok(ack_check_ok),
		.expired_seq(expired_seq), .strobe(strobe), .send_accepted(send_accepted),
		.packet_valid(packet_valid), .packet_seq(packet_seq),
		.packet_payload(packet_payload), .timer_stop(timer_stop),
		.timer_stop_seq(timer_stop_seq), .timer_start(timer_start),
		.timer_start_seq(timer_start_seq), .slide_amount(slide_amount),
		.window_base(window_base), .last(last)
	);

	always #4 clk = ~clk;

	request_t requests_to_send [$];
	res_t     due_results [$];
	request_t cur_request;
	bit       request_taken = 1'b0;
	int       n_queued = 0;
	int       n_issued = 0;
	int       n_accepted = 0;
	int       mismatches = 0;
	int       cycle_count = 0;
	int unsigned idle_share [4] = '{0, 57, 0, 38};

	// Window state as the block should hold it.
	logic [SEQ_W-1:0] win_base = '0;
	logic [SEQ_W-1:0] win_next = '0;
	int               win_count = 0;
	int               win_head = 0;
	logic [SEQ_W-1:0] held_seq [WIN];
	logic [TAG_W-1:0] held_tag [WIN];

	// Coarse window state seen by the request generator, used to aim acks.
	logic [SEQ_W-1:0] gen_base = '0;
	int               gen_count = 0;

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic compare_field(input string name, input logic [TAG_W-1:0] got,
			input logic [TAG_W-1:0] want);
		if (got !== want)
			report($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	task automatic advance_window(input request_t rq);
		res_t             r;
		int               hit;
		int               freed;
		int               slot;
		logic [SEQ_W-1:0] old_base;
		r = '0;
		r.window_base = win_base;
		r.last = 1'b1;
		case (rq.op)
			OP_SEND: begin
				if (win_count < WIN) begin
					slot = (win_head + win_count) % WIN;
					held_seq[slot] = win_next;
					held_tag[slot] = rq.tag;
					r.send_accepted = 1'b1;
					r.packet_valid = 1'b1;
					r.packet_seq = win_next;
					r.packet_payload = rq.tag;
					if (win_count == 0) begin
						r.timer_start = 1'b1;
						r.timer_start_seq = win_next;
					end
					win_next = win_next + 1'b1;
					win_count++;
				end
				due_results.insert(due_results.size(), r);
			end
			OP_ACK: begin
				hit = -1;
				if (rq.ok) begin
					for (int i = 0; i < win_count; i++) begin
						if (held_seq[(win_head + i) % WIN] == rq.ackn) begin
							hit = i;
							break;
						end
					end
				end
				if (hit >= 0) begin
					freed = hit + 1;
					old_base = win_base;
					win_head = (win_head + freed) % WIN;
					win_count -= freed;
					win_base = rq.ackn + 1'b1;
					r.window_base = win_base;
					r.timer_stop = 1'b1;
					r.timer_stop_seq = old_base;
					if (win_count != 0) begin
						r.timer_start = 1'b1;
						r.timer_start_seq = win_base;
					end
					r.slide_amount = SLIDE_W'(freed);
				end
				due_results.insert(due_results.size(), r);
			end
			OP_TIMEOUT: begin
				if (win_count == 0) begin
					r.timer_stop = 1'b1;
					r.timer_stop_seq = rq.expired;
					r.timer_start = 1'b1;
					r.timer_start_seq = rq.expired;
					due_results.insert(due_results.size(), r);
				end else begin
					// Every outstanding packet is resent, oldest first; the timer
					// requests ride on the first one only.
					for (int i = 0; i < win_count; i++) begin
						r = '0;
						r.window_base = win_base;
						r.packet_valid = 1'b1;
						r.packet_seq = held_seq[(win_head + i) % WIN];
						r.packet_payload = held_tag[(win_head + i) % WIN];
						if (i == 0) begin
							r.timer_stop = 1'b1;
							r.timer_stop_seq = rq.expired;
							r.timer_start = 1'b1;
							r.timer_start_seq = rq.expired;
						end
						r.last = (i == win_count - 1);
						due_results.insert(due_results.size(), r);
					end
				end
			end
			default: begin
				due_results.insert(due_results.size(), r);
			end
		endcase
	endtask

	task automatic queue_request(input op_t op, input logic [TAG_W-1:0] tag,
			input logic [SEQ_W-1:0] ackn, input logic ok, input logic [SEQ_W-1:0] expired);
		request_t         rq;
		logic [SEQ_W-1:0] offset;
		rq = '{op: op, tag: tag, ackn: ackn, ok: ok, expired: expired, pause: 1'b0};
		requests_to_send.insert(requests_to_send.size(), rq);
		n_queued++;
		if (op == OP_SEND && gen_count < WIN)
			gen_count++;
		if (op == OP_ACK && ok) begin
			offset = ackn - gen_base;
			if (offset < gen_count) begin
				gen_count -= offset + 1;
				gen_base = ackn + 1'b1;
			end
		end
	endtask

	task automatic queue_pause();
		request_t rq;
		rq = '{op: OP_NOP, tag: '0, ackn: '0, ok: 1'b0, expired: '0, pause: 1'b1};
		requests_to_send.insert(requests_to_send.size(), rq);
	endtask

	task automatic queue_random_request();
		int unsigned      pick;
		logic [TAG_W-1:0] tag;
		logic [SEQ_W-1:0] ackn;
		logic             ok;
		logic [SEQ_W-1:0] expired;
		pick = $urandom_range(0, 99);
		tag = $urandom;
		ackn = SEQ_W'($urandom_range(0, 7));
		ok = 1'($urandom_range(0, 1));
		expired = SEQ_W'($urandom_range(0, 7));
		if (pick < 45) begin
			queue_request(OP_SEND, tag, ackn, ok, expired);
		end else if (pick < 75) begin
			// Most acks name an outstanding packet; the rest are noise.
			if (gen_count > 0 && $urandom_range(0, 4) != 0) begin
				ackn = gen_base + SEQ_W'($urandom_range(0, gen_count - 1));
				ok = ($urandom_range(0, 9) != 0);
			end
			queue_request(OP_ACK, tag, ackn, ok, expired);
		end else if (pick < 94) begin
			if ($urandom_range(0, 3) != 0)
				expired = gen_base;
			queue_request(OP_TIMEOUT, tag, ackn, ok, expired);
		end else begin
			queue_request(OP_NOP, tag, ackn, ok, expired);
		end
	endtask

	// Driver: a new request goes out at a falling edge once the last one was taken.
	always @(negedge clk) begin : drive
		request_t rq;
		bit       issue;
		issue = 1'b0;
		if (arst_n && (!start || request_taken)) begin
			if (requests_to_send.size() > 0 && requests_to_send[0].pause) begin
				if (due_results.size() == 0)
					requests_to_send.delete(0);
			end else if (requests_to_send.size() > 0 &&
					$urandom_range(0, 99) >= idle_share[(n_issued / 60) % 4]) begin
				rq = requests_to_send[0];
				requests_to_send.delete(0);
				cur_request <= rq;
				cmd <= rq.op;
				payload_tag <= rq.tag;
				ack_number <= rq.ackn;
				ack_check_ok <= rq.ok;
				expired_seq <= rq.expired;
				n_issued++;
				issue = 1'b1;
			end
			start <= issue;
		end
	end

	// Monitor: predict on each accepted request, then check any result on the ports.
	always @(posedge clk) begin : watch
		res_t got;
		res_t want;
		request_taken = arst_n && start && !busy;
		if (request_taken) begin
			advance_window(cur_request);
			n_accepted++;
		end
		if (arst_n && strobe) begin
			got = '{send_accepted, packet_valid, packet_seq, packet_payload, timer_stop,
				timer_stop_seq, timer_start, timer_start_seq, slide_amount, window_base,
				last};
			if (due_results.size() == 0) begin
				report("result with no request pending");
			end else begin
				want = due_results[0];
				due_results.delete(0);
				compare_field("send_accepted", TAG_W'(got.send_accepted),
					TAG_W'(want.send_accepted));
				compare_field("packet_valid", TAG_W'(got.packet_valid),
					TAG_W'(want.packet_valid));
				compare_field("packet_seq", TAG_W'(got.packet_seq), TAG_W'(want.packet_seq));
				compare_field("packet_payload", got.packet_payload, want.packet_payload);
				compare_field("timer_stop", TAG_W'(got.timer_stop), TAG_W'(want.timer_stop));
				compare_field("timer_stop_seq", TAG_W'(got.timer_stop_seq),
					TAG_W'(want.timer_stop_seq));
				compare_field("timer_start", TAG_W'(got.timer_start),
					TAG_W'(want.timer_start));
				compare_field("timer_start_seq", TAG_W'(got.timer_start_seq),
					TAG_W'(want.timer_start_seq));
				compare_field("slide_amount", TAG_W'(got.slide_amount),
					TAG_W'(want.slide_amount));
				compare_field("window_base", TAG_W'(got.window_base),
					TAG_W'(want.window_base));
				compare_field("last", TAG_W'(got.last), TAG_W'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		// Empty window: timeout, stray ack, then fill it and overflow it.
		queue_request(OP_TIMEOUT, 32'h0, 3'd0, 1'b0, 3'd7);
		queue_request(OP_ACK, 32'h0, 3'd0, 1'b1, 3'd0);
		queue_request(OP_SEND, 32'h0000_0000, 3'd7, 1'b1, 3'd7);
		queue_request(OP_SEND, 32'hFFFF_FFFF, 3'd0, 1'b0, 3'd0);
		queue_request(OP_SEND, 32'hA5A5_A5A5, 3'd5, 1'b1, 3'd2);
		queue_request(OP_SEND, 32'h5A5A_5A5A, 3'd2, 1'b0, 3'd5);
		queue_request(OP_SEND, 32'h1234_5678, 3'd0, 1'b1, 3'd0);
		queue_request(OP_TIMEOUT, 32'hFFFF_FFFF, 3'd7, 1'b1, 3'd0);
		// Failed checksum, then an ack naming nothing outstanding.
		queue_request(OP_ACK, 32'h0, 3'd1, 1'b0, 3'd0);
		queue_request(OP_ACK, 32'h0, 3'd6, 1'b1, 3'd0);
		// Cumulative ack of two packets, then an unknown command.
		queue_request(OP_ACK, 32'h0, 3'd1, 1'b1, 3'd7);
		queue_request(OP_NOP, 32'hFFFF_FFFF, 3'd7, 1'b1, 3'd7);
		queue_request(OP_ACK, 32'h0, 3'd3, 1'b1, 3'd0);
		queue_request(OP_SEND, 32'h8000_0001, 3'd0, 1'b0, 3'd0);
		queue_request(OP_SEND, 32'h7FFF_FFFE, 3'd0, 1'b0, 3'd0);
		queue_request(OP_SEND, 32'hDEAD_0042, 3'd0, 1'b0, 3'd0);
		queue_request(OP_ACK, 32'h0, 3'd4, 1'b1, 3'd0);
		queue_request(OP_TIMEOUT, 32'h0, 3'd0, 1'b0, 3'd5);
		queue_request(OP_ACK, 32'h0, 3'd6, 1'b1, 3'd0);
		queue_request(OP_NOP, 32'h0, 3'd0, 1'b0, 3'd0);
		queue_pause();
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i % 100 == 99)
				queue_pause();
			queue_random_request();
		end

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_queued || due_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
